FILE: design/ktmpe_pkg.sv
// ----------------------------------------------------------------------------
// ktmpe_pkg
// Shared types and constants for the keyed table with lowest-priority
// eviction: table geometry, entry layout, scan word and commit command.
// ----------------------------------------------------------------------------
package ktmpe_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W      = 5;
  localparam int COUNT_W     = 6;

  typedef enum logic [1:0] {
    OUT_REPLACED = 2'd0,
    OUT_KEPT     = 2'd1,
    OUT_APPENDED = 2'd2,
    OUT_EVICTED  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SHIFT = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_COMMIT = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic [15:0]        subject_id;
    logic [3:0]         predicate;
    logic [15:0]        confidence;
    logic [15:0]        day_stamp;
    logic signed [15:0] payload_value;
    logic [15:0]        source_id;
    logic               truth_flag;
  } entry_t;

  typedef struct packed {
    logic             live;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic [15:0]      found_conf;
    logic             has_best;
    logic [IDX_W-1:0] best_idx;
    logic [15:0]      best_conf;
    logic [15:0]      best_day;
    logic [15:0]      best_subject;
    logic [3:0]       best_predicate;
  } wave_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] entry_count;
    logic [15:0]        evicted_subject;
    logic [3:0]         evicted_predicate;
    logic [15:0]        evicted_confidence;
  } result_t;

endpackage

FILE: design/ktmpe_cell.sv
// ----------------------------------------------------------------------------
// ktmpe_cell
// One table slot. Holds an entry, updates the passing scan word with its
// key match and rank minimum, and writes or shifts on a commit command.
// ----------------------------------------------------------------------------
module ktmpe_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [ktmpe_pkg::IDX_W-1:0] cell_idx,
  input  logic [ktmpe_pkg::CNT_W-1:0] count,
  input  ktmpe_pkg::entry_t        probe,
  input  ktmpe_pkg::cmd_t          cmd,
  input  ktmpe_pkg::entry_t        right_entry,
  input  ktmpe_pkg::wave_t         wave_in,
  output ktmpe_pkg::entry_t        entry_out,
  output ktmpe_pkg::wave_t         wave_out
);
  import ktmpe_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  wave_t  wave_r;
  wave_t  wave_nxt;
  logic   slot_valid;
  logic   key_hit;
  logic   rank_lower;

  assign slot_valid = CNT_W'(cell_idx) < count;
  assign key_hit    = (entry_r.subject_id == probe.subject_id) &&
                      (entry_r.predicate == probe.predicate);
  assign rank_lower = {entry_r.confidence, entry_r.day_stamp} <
                      {wave_in.best_conf, wave_in.best_day};

  always_comb begin
    wave_nxt = wave_in;
    if (slot_valid && !wave_in.found && key_hit) begin
      wave_nxt.found      = 1'b1;
      wave_nxt.found_idx  = cell_idx;
      wave_nxt.found_conf = entry_r.confidence;
    end
    if (slot_valid && (!wave_in.has_best || rank_lower)) begin
      wave_nxt.has_best       = 1'b1;
      wave_nxt.best_idx       = cell_idx;
      wave_nxt.best_conf      = entry_r.confidence;
      wave_nxt.best_day       = entry_r.day_stamp;
      wave_nxt.best_subject   = entry_r.subject_id;
      wave_nxt.best_predicate = entry_r.predicate;
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.kind)
      CMD_WRITE: begin
        if (cmd.idx == cell_idx) begin
          entry_nxt = probe;
        end
      end
      CMD_SHIFT: begin
        if (cell_idx >= cmd.idx) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.live <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign entry_out = entry_r;
  assign wave_out  = wave_r;

  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wave_in.live |-> cmd.kind == CMD_NONE)
    else $error("cell commanded while a scan word passes");

  a_found_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wave_in.live && !wave_in.found && wave_nxt.found) |-> slot_valid)
    else $error("match reported from an empty slot");

  a_best_set_after_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wave_in.live && slot_valid) |-> wave_nxt.has_best)
    else $error("valid slot left the minimum unset");

endmodule

FILE: design/ktmpe_ctrl.sv
// ----------------------------------------------------------------------------
// ktmpe_ctrl
// Sequencer for the table: takes a word, launches the scan through the
// cell row, decides replace, keep, append or evict, and holds the result.
// ----------------------------------------------------------------------------
module ktmpe_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  ktmpe_pkg::entry_t             in_entry,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output ktmpe_pkg::result_t            out_result,
  output ktmpe_pkg::entry_t             probe,
  output ktmpe_pkg::wave_t              wave_launch,
  input  ktmpe_pkg::wave_t              wave_end,
  output ktmpe_pkg::cmd_t               cmd,
  output logic [ktmpe_pkg::CNT_W-1:0]   count
);
  import ktmpe_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  entry_t      probe_r;
  logic        launch_r;
  wave_t       done_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic        out_valid_r;
  result_t     result_r;
  result_t     result_nxt;
  cmd_t        decided;
  logic        accept;
  logic        out_free;
  logic        commit_go;
  logic        table_full;

  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign table_full = count_r == CNT_W'(TABLE_DEPTH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (wave_end.live) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    commit_go = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_COMMIT: begin
        commit_go = out_free;
      end
      default: begin
        in_tready = 1'b0;
        commit_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    decided    = '{kind: CMD_NONE, idx: '0};
    count_nxt  = count_r;
    result_nxt = '0;
    if (done_r.found) begin
      result_nxt.slot_index = SLOT_W'(done_r.found_idx);
      if (probe_r.confidence >= done_r.found_conf) begin
        decided.kind       = CMD_WRITE;
        decided.idx        = done_r.found_idx;
        result_nxt.outcome = OUT_REPLACED;
      end else begin
        result_nxt.outcome = OUT_KEPT;
      end
    end else if (table_full) begin
      decided.kind                  = CMD_SHIFT;
      decided.idx                   = done_r.best_idx;
      result_nxt.outcome            = OUT_EVICTED;
      result_nxt.slot_index         = SLOT_W'(TABLE_DEPTH - 1);
      result_nxt.evicted_subject    = done_r.best_subject;
      result_nxt.evicted_predicate  = done_r.best_predicate;
      result_nxt.evicted_confidence = done_r.best_conf;
    end else begin
      decided.kind          = CMD_WRITE;
      decided.idx           = IDX_W'(count_r);
      count_nxt             = count_r + CNT_W'(1);
      result_nxt.outcome    = OUT_APPENDED;
      result_nxt.slot_index = SLOT_W'(count_r);
    end
    result_nxt.entry_count = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= accept;
      if (commit_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe_r <= in_entry;
    end
    if (state_r == S_SCAN && wave_end.live) begin
      done_r <= wave_end;
    end
    if (commit_go) begin
      result_r <= result_nxt;
    end
  end

  always_comb begin
    wave_launch      = '0;
    wave_launch.live = launch_r;
  end

  assign probe      = probe_r;
  assign cmd        = commit_go ? decided : cmd_t'{kind: CMD_NONE, idx: '0};
  assign count      = count_r;
  assign out_tvalid = out_valid_r;
  assign out_result = result_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wave_end.live |-> state_r == S_SCAN)
    else $error("scan word arrived outside a scan");

  a_shift_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.kind == CMD_SHIFT |-> table_full)
    else $error("eviction issued on a table that is not full");

  a_commit_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> out_tvalid)
    else $error("commit did not present a result");

endmodule

FILE: design/keyed_table_min_priority_evict.sv
// ----------------------------------------------------------------------------
// keyed_table_min_priority_evict
// Keyed table with lowest-priority eviction, built as a row of slot cells
// through which a scan word walks, followed by a commit state.
// ----------------------------------------------------------------------------
// Result: a result word is presented once its input word has passed the launch
// register, the register of every cell in the row and the commit state.
// Input: a new word is accepted only in the idle state, after the scan word has
// stepped one cell per cycle down the row and the last result has been committed.
// Reset: synchronous, active low; the table empties at once (count zero), the
// slot contents are left as they are and are never read until written.
module keyed_table_min_priority_evict (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // subject_id[15:0], predicate[19:16], confidence[35:20], day_stamp[51:36],
  // payload_value[67:52], source_id[83:68], truth_flag[84], zero[87:85]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot_index[4:0], entry_count[10:5], evicted_subject[26:11],
  // evicted_predicate[30:27], evicted_confidence[46:31], zero[47]
  output logic [47:0] out_tdata,
  // outcome[1:0]
  output logic [1:0]  out_tuser
);
  import ktmpe_pkg::*;

  entry_t           in_entry;
  entry_t           probe;
  wave_t            wave_link [TABLE_DEPTH+1];
  entry_t           entry_link [TABLE_DEPTH+1];
  cmd_t             cmd;
  logic [CNT_W-1:0] count;
  result_t          result;

  always_comb begin
    in_entry.subject_id    = in_tdata[15:0];
    in_entry.predicate     = in_tdata[19:16];
    in_entry.confidence    = in_tdata[35:20];
    in_entry.day_stamp     = in_tdata[51:36];
    in_entry.payload_value = in_tdata[67:52];
    in_entry.source_id     = in_tdata[83:68];
    in_entry.truth_flag    = in_tdata[84];
  end

  ktmpe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_entry    (in_entry),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_result  (result),
    .probe       (probe),
    .wave_launch (wave_link[0]),
    .wave_end    (wave_link[TABLE_DEPTH]),
    .cmd         (cmd),
    .count       (count)
  );

  assign entry_link[TABLE_DEPTH] = probe;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ktmpe_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(g)),
      .count       (count),
      .probe       (probe),
      .cmd         (cmd),
      .right_entry (entry_link[g+1]),
      .wave_in     (wave_link[g]),
      .entry_out   (entry_link[g]),
      .wave_out    (wave_link[g+1])
    );
  end

  assign out_tuser = result.outcome;
  assign out_tdata = {1'b0, result.evicted_confidence, result.evicted_predicate,
                      result.evicted_subject, result.entry_count, result.slot_index};

endmodule

FILE: dv/tb_keyed_table_min_priority_evict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_table_min_priority_evict
// Self-checking bench for the keyed table with lowest-priority eviction. A
// scoreboard class keeps its own copy of the table, works out the result of
// every accepted input word and compares each output word against the oldest
// pending result. A short directed run covers field extremes, replace, keep
// and equal-confidence cases. Random words then fill the table, hit stored
// keys and force evictions with ties. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_keyed_table_min_priority_evict;
  import ktmpe_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1400;
  localparam int PRINT_LIMIT  = 100;

  class evict_table_sb;
    logic [19:0] keys [TABLE_DEPTH];
    logic [31:0] ranks [TABLE_DEPTH];
    logic [32:0] payloads [TABLE_DEPTH];
    int unsigned fill;
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report_mismatch(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= PRINT_LIMIT) begin
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
      end
    endtask

    function void note_offer(logic [87:0] word);
      logic [19:0] key;
      logic [31:0] rank;
      logic [32:0] pay;
      result_t     res;
      int unsigned hit;
      int unsigned worst;
      bit          found;

      key   = {word[15:0], word[19:16]};
      rank  = {word[35:20], word[51:36]};
      pay   = {word[67:52], word[83:68], word[84]};
      res   = '0;
      found = 0;
      hit   = 0;
      for (int i = 0; i < fill; i++) begin
        if (!found && keys[i] == key) begin
          found = 1;
          hit   = i;
        end
      end
      if (found) begin
        if (rank[31:16] >= ranks[hit][31:16]) begin
          keys[hit]     = key;
          ranks[hit]    = rank;
          payloads[hit] = pay;
          res.outcome   = OUT_REPLACED;
        end else begin
          res.outcome = OUT_KEPT;
        end
        res.slot_index = hit[SLOT_W-1:0];
      end else if (fill == TABLE_DEPTH) begin
        worst = 0;
        for (int i = 1; i < fill; i++) begin
          if (ranks[i] < ranks[worst]) worst = i;
        end
        res.evicted_subject    = keys[worst][19:4];
        res.evicted_predicate  = keys[worst][3:0];
        res.evicted_confidence = ranks[worst][31:16];
        for (int i = worst; i + 1 < fill; i++) begin
          keys[i]     = keys[i + 1];
          ranks[i]    = ranks[i + 1];
          payloads[i] = payloads[i + 1];
        end
        keys[fill - 1]     = key;
        ranks[fill - 1]    = rank;
        payloads[fill - 1] = pay;
        res.slot_index     = SLOT_W'(fill - 1);
        res.outcome        = OUT_EVICTED;
      end else begin
        keys[fill]     = key;
        ranks[fill]    = rank;
        payloads[fill] = pay;
        res.slot_index = SLOT_W'(fill);
        fill++;
        res.outcome    = OUT_APPENDED;
      end
      res.entry_count = COUNT_W'(fill);
      pending_results.push_front(res);
    endfunction

    task check_result(logic [1:0] user, logic [47:0] data);
      result_t want;

      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 0, data[31:0]);
      end else begin
        want = pending_results.pop_back();
        if (want.outcome != user) report_mismatch("outcome", want.outcome, user);
        if (want.slot_index != data[4:0])
          report_mismatch("slot_index", want.slot_index, data[4:0]);
        if (want.entry_count != data[10:5])
          report_mismatch("entry_count", want.entry_count, data[10:5]);
        if (want.evicted_subject != data[26:11])
          report_mismatch("evicted_subject", want.evicted_subject, data[26:11]);
        if (want.evicted_predicate != data[30:27])
          report_mismatch("evicted_predicate", want.evicted_predicate, data[30:27]);
        if (want.evicted_confidence != data[46:31])
          report_mismatch("evicted_confidence", want.evicted_confidence, data[46:31]);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  evict_table_sb sb;
  int unsigned   idle_cycles = 0;
  int unsigned   ready_hold = 0;
  int unsigned   burst_left = 0;

  keyed_table_min_priority_evict DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_tready <= 1'b1;
          ready_hold <= $urandom_range(0, 19);
        end
        5, 6, 7: begin
          out_tready <= 1'b0;
          ready_hold <= $urandom_range(0, 2);
        end
        8: begin
          out_tready <= 1'b0;
          ready_hold <= $urandom_range(3, 59);
        end
        default: begin
          out_tready <= 1'b1;
          ready_hold <= $urandom_range(40, 200);
        end
      endcase
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_offer(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with no word moving", $realtime);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic entry_t make_entry(logic [15:0] subj, logic [3:0] pred,
                                        logic [15:0] conf, logic [15:0] day,
                                        logic [15:0] val, logic [15:0] src,
                                        logic tru);
    entry_t e;

    e.subject_id    = subj;
    e.predicate     = pred;
    e.confidence    = conf;
    e.day_stamp     = day;
    e.payload_value = val;
    e.source_id     = src;
    e.truth_flag    = tru;
    return e;
  endfunction

  task automatic send_word(entry_t e);
    int unsigned gap;
    int unsigned roll;

    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll <= 2) begin
        burst_left = $urandom_range(10, 40);
        gap        = 0;
      end else if (roll <= 39) begin
        gap = 0;
      end else if (roll <= 84) begin
        gap = $urandom_range(1, 4);
      end else if (roll <= 94) begin
        gap = $urandom_range(5, 40);
      end else begin
        gap = $urandom_range(41, 120);
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, e.truth_flag, e.source_id, e.payload_value, e.day_stamp,
                  e.confidence, e.predicate, e.subject_id};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [15:0] pick_conf();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 3));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_day();
    case ($urandom_range(0, 7))
      0, 1:    return 16'($urandom_range(0, 1));
      2:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random_word();
    logic [15:0] subj;
    logic [3:0]  pred;
    logic [15:0] conf;
    logic [15:0] stored;
    int unsigned pick;
    int unsigned choice;

    choice = $urandom_range(0, 99);
    conf   = pick_conf();
    if (choice < 40 && sb.fill > 0) begin
      pick   = $urandom_range(0, sb.fill - 1);
      subj   = sb.keys[pick][19:4];
      pred   = sb.keys[pick][3:0];
      stored = sb.ranks[pick][31:16];
      case ($urandom_range(0, 3))
        0: conf = stored;
        1: conf = stored - 16'd1;
        2: conf = stored + 16'd1;
        default: ;
      endcase
    end else if (choice < 65) begin
      subj = 16'($urandom_range(0, 15));
      pred = 4'($urandom_range(0, 3));
    end else begin
      subj = 16'($urandom());
      pred = 4'($urandom());
    end
    send_word(make_entry(subj, pred, conf, pick_day(), 16'($urandom()), 16'($urandom()),
                         1'($urandom())));
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_entry(16'h0000, 4'h0, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0));
    send_word(make_entry(16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b1));
    send_word(make_entry(16'h0000, 4'h0, 16'h0000, 16'h0005, 16'h0001, 16'h0002, 1'b1));
    send_word(make_entry(16'hFFFF, 4'hF, 16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_word(make_entry(16'hFFFF, 4'hF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0));
    send_word(make_entry(16'h0000, 4'h0, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
    send_word(make_entry(16'h0000, 4'hF, 16'h8000, 16'h8000, 16'hFF00, 16'h5A5A, 1'b1));
    send_word(make_entry(16'hFFFF, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_word(make_entry(16'h0000, 4'h0, 16'h0000, 16'h0001, 16'h1234, 16'h4321, 1'b1));
    send_word(make_entry(16'h1234, 4'h5, 16'h8000, 16'h8000, 16'h0100, 16'hA5A5, 1'b1));
    send_word(make_entry(16'h1234, 4'h5, 16'h7FFF, 16'h0001, 16'h0000, 16'h0000, 1'b0));
    send_word(make_entry(16'h1234, 4'h5, 16'hFFFF, 16'h0002, 16'hFFFF, 16'hFFFF, 1'b1));
    send_word(make_entry(16'h8000, 4'h8, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));

    repeat (RANDOM_WORDS) send_random_word();
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
